[rtl/assert_macros.svh]
// Assertion macros shared by the page bitmap range marker RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and off during reset
`define PBM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbm assertion failed");

// Next-cycle implication, sampled on clk and off during reset
`define PBM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbm assertion failed");

`else

`define PBM_ASSERT_IMP(label, ante, cons)
`define PBM_ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/pbm_pkg.sv]
// Shared constants, types and helper functions of the page bitmap range marker.
// Used by pbm_ctrl, pbm_datapath and page_bitmap_range_marker; no dependencies.
package pbm_pkg;

    // Address space and page geometry
    localparam int ADDR_BITS       = 32;
    localparam int PAGE_SHIFT      = 12;
    localparam int PAGES_PER_ENTRY = 8;
    localparam int IN_ADDR_W       = 32;

    // Derived widths
    localparam int ENTRY_W     = PAGES_PER_ENTRY;
    localparam int SLOT_BITS   = $clog2(PAGES_PER_ENTRY);
    localparam int PAGE_W      = ADDR_BITS - PAGE_SHIFT;
    localparam int IDX_W       = PAGE_W - SLOT_BITS;
    localparam int STORE_DEPTH = 1 << IDX_W;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [PAGE_W-1:0]    page_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [ENTRY_W-1:0]   entry_t;

    localparam entry_t FULL_ENTRY = {ENTRY_W{1'b1}};
    localparam entry_t ZERO_ENTRY = {ENTRY_W{1'b0}};
    localparam slot_t  SLOT_FIRST = {SLOT_BITS{1'b0}};
    localparam slot_t  SLOT_LAST  = {SLOT_BITS{1'b1}};

    // Request and response codes
    localparam logic REQ_UPDATE  = 1'b0;
    localparam logic REQ_QUERY   = 1'b1;
    localparam logic RESP_UPDATE = 1'b0;
    localparam logic RESP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FIRST_RD,
        ST_FIRST_WR,
        ST_MID_WR,
        ST_LAST_RD,
        ST_LAST_WR,
        ST_QUERY_RD,
        ST_QUERY_CHK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ADDR_CLR,
        ADDR_FIRST,
        ADDR_WALK,
        ADDR_LAST,
        ADDR_QUERY
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_FIRST,
        WD_LAST,
        WD_FULL
    } wdata_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       dec_load;
        logic       walk_init;
        logic       walk_inc;
        logic       clr_inc;
        logic       ram_re;
        logic       ram_we;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       fail_load;
        logic       out_load;
    } pbm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic noop;
        logic single_entry;
        logic first_to_last;
        logic walk_last;
        logic out_free;
    } pbm_status_t;

    // Keep the low ADDR_BITS bits of an input address, zero-extending if narrower
    function automatic addr_t mask_addr(input logic [IN_ADDR_W-1:0] a);
        logic [IN_ADDR_W+ADDR_BITS-1:0] t;
        t = {{ADDR_BITS{1'b0}}, a};
        return t[ADDR_BITS-1:0];
    endfunction

    // Bits lo..hi set, inclusive
    function automatic entry_t span_mask(input slot_t lo, input slot_t hi);
        entry_t up;
        entry_t dn;
        up = FULL_ENTRY << lo;
        dn = FULL_ENTRY >> (SLOT_LAST - hi);
        return up & dn;
    endfunction

endpackage

[rtl/pbm_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module pbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, register read data on re
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pbm_datapath.sv]
// Datapath of the page bitmap range marker: request capture, range decode,
// byte walk counters, bitmap store and result register. Uses pbm_pkg, pbm_ram.
module pbm_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_type,
    input  logic [pbm_pkg::IN_ADDR_W-1:0]      range_start_addr,
    input  logic [pbm_pkg::IN_ADDR_W-1:0]      range_end_addr,
    input  logic                               set_value,
    input  logic [pbm_pkg::IN_ADDR_W-1:0]      query_addr,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic                               resp_kind,
    output logic                               check_failed,
    input  pbm_pkg::pbm_cmd_t                  cmd,
    output pbm_pkg::pbm_status_t               status
);

    pbm_pkg::addr_t  start_m;
    pbm_pkg::addr_t  end_m;
    pbm_pkg::addr_t  query_m;

    logic            kind_reg;
    logic            set_reg;
    pbm_pkg::page_t  sp_reg;
    pbm_pkg::page_t  ep_reg;
    pbm_pkg::page_t  qp_reg;

    pbm_pkg::page_t  last_page;
    pbm_pkg::idx_t   sb_reg;
    pbm_pkg::idx_t   eb_reg;
    pbm_pkg::slot_t  lo_reg;
    pbm_pkg::slot_t  hi_reg;

    pbm_pkg::idx_t   walk_reg;
    pbm_pkg::idx_t   walk_next;
    pbm_pkg::idx_t   clr_reg;
    pbm_pkg::idx_t   clr_next;

    logic            fail_reg;
    logic            out_valid_reg;
    logic            resp_kind_reg;
    logic            check_failed_reg;

    pbm_pkg::idx_t   ram_addr;
    pbm_pkg::entry_t ram_wdata;
    pbm_pkg::entry_t ram_rdata;
    pbm_pkg::entry_t mask_first;
    pbm_pkg::entry_t mask_last;
    pbm_pkg::idx_t   sb_plus1;
    pbm_pkg::slot_t  qslot;

    // Mask incoming addresses to the address space
    always_comb
    begin
        start_m = pbm_pkg::mask_addr(range_start_addr);
        end_m   = pbm_pkg::mask_addr(range_end_addr);
        query_m = pbm_pkg::mask_addr(query_addr);
    end

    // Capture the request beat as page numbers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req_type;
            set_reg  <= set_value;
            sp_reg   <= start_m[pbm_pkg::ADDR_BITS-1:pbm_pkg::PAGE_SHIFT];
            ep_reg   <= end_m[pbm_pkg::ADDR_BITS-1:pbm_pkg::PAGE_SHIFT];
            qp_reg   <= query_m[pbm_pkg::ADDR_BITS-1:pbm_pkg::PAGE_SHIFT];
        end
    end

    // Split the page range into first and last store bytes
    assign last_page = ep_reg - pbm_pkg::page_t'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.dec_load)
        begin
            sb_reg <= sp_reg[pbm_pkg::PAGE_W-1:pbm_pkg::SLOT_BITS];
            lo_reg <= sp_reg[pbm_pkg::SLOT_BITS-1:0];
            eb_reg <= last_page[pbm_pkg::PAGE_W-1:pbm_pkg::SLOT_BITS];
            hi_reg <= last_page[pbm_pkg::SLOT_BITS-1:0];
        end
    end

    // Advance the middle-byte walk
    always_comb
    begin
        walk_next = walk_reg;
        if (cmd.walk_init)
        begin
            walk_next = sb_plus1;
        end
        else if (cmd.walk_inc)
        begin
            walk_next = walk_reg + pbm_pkg::idx_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
    end

    // Advance the clearing sweep after reset
    assign clr_next = clr_reg + pbm_pkg::idx_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_inc)
        begin
            clr_reg <= clr_next;
        end
    end

    // Edge masks and write data
    assign sb_plus1   = sb_reg + pbm_pkg::idx_t'(1);
    assign mask_first = pbm_pkg::span_mask(lo_reg,
                            (sb_reg == eb_reg) ? hi_reg : pbm_pkg::SLOT_LAST);
    assign mask_last  = pbm_pkg::span_mask(pbm_pkg::SLOT_FIRST, hi_reg);

    always_comb
    begin
        case (cmd.wdata_sel)
            pbm_pkg::WD_ZERO:
                ram_wdata = pbm_pkg::ZERO_ENTRY;
            pbm_pkg::WD_FIRST:
                ram_wdata = set_reg ? (ram_rdata | mask_first) : (ram_rdata & ~mask_first);
            pbm_pkg::WD_LAST:
                ram_wdata = set_reg ? (ram_rdata | mask_last) : (ram_rdata & ~mask_last);
            pbm_pkg::WD_FULL:
                ram_wdata = set_reg ? pbm_pkg::FULL_ENTRY : pbm_pkg::ZERO_ENTRY;
            default:
                ram_wdata = pbm_pkg::ZERO_ENTRY;
        endcase
    end

    // Select the store address
    always_comb
    begin
        case (cmd.addr_sel)
            pbm_pkg::ADDR_CLR:   ram_addr = clr_reg;
            pbm_pkg::ADDR_FIRST: ram_addr = sb_reg;
            pbm_pkg::ADDR_WALK:  ram_addr = walk_reg;
            pbm_pkg::ADDR_LAST:  ram_addr = eb_reg;
            pbm_pkg::ADDR_QUERY: ram_addr = qp_reg[pbm_pkg::PAGE_W-1:pbm_pkg::SLOT_BITS];
            default:             ram_addr = clr_reg;
        endcase
    end

    pbm_ram #(
        .WIDTH (pbm_pkg::ENTRY_W),
        .DEPTH (pbm_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (cmd.ram_we),
        .wdata (ram_wdata),
        .re    (cmd.ram_re),
        .rdata (ram_rdata)
    );

    // Test the queried page bit
    assign qslot = qp_reg[pbm_pkg::SLOT_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.fail_load)
        begin
            fail_reg <= ~ram_rdata[qslot];
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            resp_kind_reg    <= (kind_reg == pbm_pkg::REQ_QUERY) ?
                                pbm_pkg::RESP_QUERY : pbm_pkg::RESP_UPDATE;
            check_failed_reg <= (kind_reg == pbm_pkg::REQ_QUERY) & fail_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign resp_kind    = resp_kind_reg;
    assign check_failed = check_failed_reg;

    // Status back to the controller
    always_comb
    begin
        status.clr_done      = (clr_reg == pbm_pkg::idx_t'(pbm_pkg::STORE_DEPTH - 1));
        status.is_query      = (kind_reg == pbm_pkg::REQ_QUERY);
        status.noop          = (ep_reg <= sp_reg);
        status.single_entry  = (sb_reg == eb_reg);
        status.first_to_last = (sb_plus1 == eb_reg);
        status.walk_last     = ((walk_reg + pbm_pkg::idx_t'(1)) == eb_reg);
        status.out_free      = !out_valid_reg || out_ready;
    end

endmodule

[rtl/pbm_ctrl.sv]
// Controller of the page bitmap range marker: sequences the clearing sweep,
// range updates and queries. Uses pbm_pkg.
module pbm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pbm_pkg::pbm_status_t  status,
    output pbm_pkg::pbm_cmd_t     cmd
);

    pbm_pkg::state_t state_reg;
    pbm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbm_pkg::ST_CLEAR:
                if (status.clr_done)
                    state_next = pbm_pkg::ST_IDLE;
            pbm_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pbm_pkg::ST_DECODE;
            pbm_pkg::ST_DECODE:
                if (status.is_query)
                    state_next = pbm_pkg::ST_QUERY_RD;
                else if (status.noop)
                    state_next = pbm_pkg::ST_FINISH;
                else
                    state_next = pbm_pkg::ST_FIRST_RD;
            pbm_pkg::ST_FIRST_RD:
                state_next = pbm_pkg::ST_FIRST_WR;
            pbm_pkg::ST_FIRST_WR:
                if (status.single_entry)
                    state_next = pbm_pkg::ST_FINISH;
                else if (status.first_to_last)
                    state_next = pbm_pkg::ST_LAST_RD;
                else
                    state_next = pbm_pkg::ST_MID_WR;
            pbm_pkg::ST_MID_WR:
                if (status.walk_last)
                    state_next = pbm_pkg::ST_LAST_RD;
            pbm_pkg::ST_LAST_RD:
                state_next = pbm_pkg::ST_LAST_WR;
            pbm_pkg::ST_LAST_WR:
                state_next = pbm_pkg::ST_FINISH;
            pbm_pkg::ST_QUERY_RD:
                state_next = pbm_pkg::ST_QUERY_CHK;
            pbm_pkg::ST_QUERY_CHK:
                state_next = pbm_pkg::ST_FINISH;
            pbm_pkg::ST_FINISH:
                if (status.out_free)
                    state_next = pbm_pkg::ST_IDLE;
            default:
                state_next = pbm_pkg::ST_CLEAR;
        endcase
    end

    // Commands
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.addr_sel  = pbm_pkg::ADDR_CLR;
        cmd.wdata_sel = pbm_pkg::WD_ZERO;
        unique case (state_reg)
            pbm_pkg::ST_CLEAR:
            begin
                cmd.ram_we  = 1'b1;
                cmd.clr_inc = 1'b1;
            end
            pbm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pbm_pkg::ST_DECODE:
                cmd.dec_load = 1'b1;
            pbm_pkg::ST_FIRST_RD:
            begin
                cmd.addr_sel = pbm_pkg::ADDR_FIRST;
                cmd.ram_re   = 1'b1;
            end
            pbm_pkg::ST_FIRST_WR:
            begin
                cmd.addr_sel  = pbm_pkg::ADDR_FIRST;
                cmd.wdata_sel = pbm_pkg::WD_FIRST;
                cmd.ram_we    = 1'b1;
                cmd.walk_init = 1'b1;
            end
            pbm_pkg::ST_MID_WR:
            begin
                cmd.addr_sel  = pbm_pkg::ADDR_WALK;
                cmd.wdata_sel = pbm_pkg::WD_FULL;
                cmd.ram_we    = 1'b1;
                cmd.walk_inc  = 1'b1;
            end
            pbm_pkg::ST_LAST_RD:
            begin
                cmd.addr_sel = pbm_pkg::ADDR_LAST;
                cmd.ram_re   = 1'b1;
            end
            pbm_pkg::ST_LAST_WR:
            begin
                cmd.addr_sel  = pbm_pkg::ADDR_LAST;
                cmd.wdata_sel = pbm_pkg::WD_LAST;
                cmd.ram_we    = 1'b1;
            end
            pbm_pkg::ST_QUERY_RD:
            begin
                cmd.addr_sel = pbm_pkg::ADDR_QUERY;
                cmd.ram_re   = 1'b1;
            end
            pbm_pkg::ST_QUERY_CHK:
                cmd.fail_load = 1'b1;
            pbm_pkg::ST_FINISH:
                cmd.out_load = status.out_free;
            default:
                cmd.load = 1'b0;
        endcase
    end

endmodule

[rtl/page_bitmap_range_marker.sv]
// Page bitmap range marker: one mark bit per page, eight pages per store byte.
// Uses pbm_pkg, pbm_ctrl, pbm_datapath (with pbm_ram) and assert_macros.svh.
//
// Input channel (in_valid/in_ready) carries one request per beat: an update
// (req_type 0) sets or clears the marks of all pages from the page of
// range_start_addr up to, not including, the page of range_end_addr; a query
// (req_type 1) tests the mark of the page of query_addr.
// Output channel (out_valid/out_ready) returns one beat per request:
// resp_kind 0 for a finished update, 1 for a query with check_failed set
// when the page mark is clear.
// One request is in flight at a time. A query reads the store, then tests the
// page mark. An update rewrites the first byte, the middle bytes and the last
// byte in turn (only the first for a single byte, none for an empty range);
// the single-port store writes one byte per cycle, with a read-modify-write
// at each end. After reset the store is swept to zero, one byte per cycle,
// over 131072 bytes by default; in_ready stays low until the sweep is done.
// A finished result sits in an output register; while the receiver stalls,
// the block holds that result and a new request can be accepted and worked
// on, pausing only when its own result is ready and the register is full.
module page_bitmap_range_marker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [pbm_pkg::IN_ADDR_W-1:0] range_start_addr,
    input  logic [pbm_pkg::IN_ADDR_W-1:0] range_end_addr,
    input  logic                          set_value,
    input  logic [pbm_pkg::IN_ADDR_W-1:0] query_addr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          resp_kind,
    output logic                          check_failed
);

    `include "assert_macros.svh"

    pbm_pkg::pbm_cmd_t    cmd;
    pbm_pkg::pbm_status_t status;

    pbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pbm_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_type         (req_type),
        .range_start_addr (range_start_addr),
        .range_end_addr   (range_end_addr),
        .set_value        (set_value),
        .query_addr       (query_addr),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .resp_kind        (resp_kind),
        .check_failed     (check_failed),
        .cmd              (cmd),
        .status           (status)
    );

    // No store write while waiting for a request
    `PBM_ASSERT_IMP(a_idle_no_write, in_ready, !cmd.ram_we)
    // Single store port: never read and write together
    `PBM_ASSERT_IMP(a_one_port_op, cmd.ram_we, !cmd.ram_re)
    // One request at a time
    `PBM_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // A taken result leaves unless a new one is loaded
    `PBM_ASSERT_NXT(a_out_drains, out_valid && out_ready && !cmd.out_load, !out_valid)

endmodule

[verif/tb.sv]
// Self-checking testbench for page_bitmap_range_marker: tracks the page marks
// in a scoreboard class and checks every response beat. Depends on pbm_pkg.
`timescale 1ns / 1ps

module tb;
    import pbm_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int SETTLE_CYCLES  = 16;
    // A full-range update walks the whole store, as does the sweep after reset
    localparam int WATCHDOG_LIMIT = 4 * STORE_DEPTH + 1000;

    typedef struct packed {
        logic kind;
        logic failed;
    } resp_beat_t;

    // Scoreboard: shadow copy of the page marks plus the responses still owed
    class page_mark_tracker;
        bit [ENTRY_W-1:0] marks [STORE_DEPTH];
        resp_beat_t       awaited_q [$];
        int               n_update;
        int               n_no_change;
        int               n_query;
        int               n_clear_hit;
        int               errors;

        // Set or clear the marks of pages first_a up to, not including, stop_a
        function void mark_pages(input addr_t first_a, input addr_t stop_a,
                                 input bit set_marks);
            page_t            first_p;
            page_t            stop_p;
            page_t            last_p;
            int unsigned      first_b;
            int unsigned      last_b;
            int unsigned      b;
            bit [ENTRY_W-1:0] m;
            first_p = first_a[ADDR_BITS-1:PAGE_SHIFT];
            stop_p  = stop_a[ADDR_BITS-1:PAGE_SHIFT];
            // Drop reversed ranges and ranges within a single page
            if (stop_a < first_a || stop_p <= first_p)
            begin
                n_no_change++;
                return;
            end
            last_p  = stop_p - 1'b1;
            first_b = 32'(first_p[PAGE_W-1:SLOT_BITS]);
            last_b  = 32'(last_p[PAGE_W-1:SLOT_BITS]);
            for (b = first_b; b <= last_b; b++)
            begin
                m = FULL_ENTRY;
                if (b == first_b)
                    m = m & (FULL_ENTRY << first_p[SLOT_BITS-1:0]);
                if (b == last_b)
                    m = m & (FULL_ENTRY >> (SLOT_LAST - last_p[SLOT_BITS-1:0]));
                if (set_marks)
                    marks[idx_t'(b)] = marks[idx_t'(b)] | m;
                else
                    marks[idx_t'(b)] = marks[idx_t'(b)] & ~m;
            end
        endfunction

        // Apply an accepted request beat and queue the response it owes
        function void note_request(input logic kind,
                                   input logic [IN_ADDR_W-1:0] lo_a,
                                   input logic [IN_ADDR_W-1:0] hi_a,
                                   input logic set_marks,
                                   input logic [IN_ADDR_W-1:0] probe_a);
            resp_beat_t r;
            addr_t      a;
            page_t      p;
            if (kind == REQ_UPDATE)
            begin
                mark_pages(addr_t'(lo_a), addr_t'(hi_a), set_marks);
                r.kind   = RESP_UPDATE;
                r.failed = 1'b0;
                n_update++;
            end
            else
            begin
                a        = addr_t'(probe_a);
                p        = a[ADDR_BITS-1:PAGE_SHIFT];
                r.kind   = RESP_QUERY;
                r.failed = ~marks[p[PAGE_W-1:SLOT_BITS]][p[SLOT_BITS-1:0]];
                n_query++;
                if (r.failed)
                    n_clear_hit++;
            end
            awaited_q.push_back(r);
        endfunction

        // Compare a response beat with the oldest one owed
        function void check_response(input logic kind, input logic failed);
            resp_beat_t want;
            if (awaited_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response beat, resp_kind %0d check_failed %0d",
                         $time, kind, failed);
                return;
            end
            want = awaited_q.pop_front();
            if (kind !== want.kind)
            begin
                errors++;
                $display("%0t: resp_kind expected %0d actual %0d",
                         $time, want.kind, kind);
            end
            if (failed !== want.failed)
            begin
                errors++;
                $display("%0t: check_failed expected %0d actual %0d",
                         $time, want.failed, failed);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 req_type;
    logic [IN_ADDR_W-1:0] range_start_addr;
    logic [IN_ADDR_W-1:0] range_end_addr;
    logic                 set_value;
    logic [IN_ADDR_W-1:0] query_addr;
    logic                 out_valid;
    logic                 out_ready;
    logic                 resp_kind;
    logic                 check_failed;

    page_mark_tracker tracker;
    bit               quiet;
    bit               hold_off_req;

    page_bitmap_range_marker i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .range_start_addr (range_start_addr),
        .range_end_addr   (range_end_addr),
        .set_value        (set_value),
        .query_addr       (query_addr),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .resp_kind        (resp_kind),
        .check_failed     (check_failed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Address in one of a few small page windows, so queries hit marked pages
    function automatic logic [IN_ADDR_W-1:0] hot_addr();
        page_t                 page;
        logic [PAGE_SHIFT-1:0] offs;
        case ($urandom_range(0, 3))
            0:       page = '0;
            1:       page = page_t'(1) << (PAGE_W - 2);
            2:       page = (page_t'(1) << (PAGE_W - 1)) - page_t'(64);
            default: page = '1 - page_t'(127);
        endcase
        page = page + page_t'($urandom_range(0, 127));
        offs = ($urandom_range(0, 1) != 0) ? '0 : PAGE_SHIFT'($urandom);
        return IN_ADDR_W'({page, offs});
    endfunction

    // End address a number of pages past base, page aligned or not
    function automatic logic [IN_ADDR_W-1:0] page_end(input logic [IN_ADDR_W-1:0] base,
                                                      input int unsigned pages);
        logic [IN_ADDR_W-1:0] e;
        e = base + (IN_ADDR_W'(pages) << PAGE_SHIFT);
        if ($urandom_range(0, 1) != 0)
            e[PAGE_SHIFT-1:0] = '0;
        else
            e[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
        return e;
    endfunction

    // Offer one request beat, hold it until accepted, then maybe idle
    task automatic offer_request(input logic kind,
                                 input logic [IN_ADDR_W-1:0] lo_a,
                                 input logic [IN_ADDR_W-1:0] hi_a,
                                 input logic set_marks,
                                 input logic [IN_ADDR_W-1:0] probe_a);
        req_type         <= kind;
        range_start_addr <= lo_a;
        range_end_addr   <= hi_a;
        set_value        <= set_marks;
        query_addr       <= probe_a;
        in_valid         <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(kind, lo_a, hi_a, set_marks, probe_a);
        if (!quiet && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Fill the fields an update ignores with random values
    task automatic send_update(input logic [IN_ADDR_W-1:0] lo_a,
                               input logic [IN_ADDR_W-1:0] hi_a,
                               input logic set_marks);
        offer_request(REQ_UPDATE, lo_a, hi_a, set_marks, $urandom);
    endtask

    // Fill the fields a query ignores with random values
    task automatic send_query(input logic [IN_ADDR_W-1:0] probe_a);
        offer_request(REQ_QUERY, $urandom, $urandom, 1'($urandom), probe_a);
    endtask

    // Stop offering and wait until every owed response has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.awaited_q.size() != 0);
    endtask

    // Response side: check each accepted beat, stall at random or on request
    initial
    begin : response_sink
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_response(resp_kind, check_failed);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ready   <= 1'b0;
            end
            else if (hold_left > 0)
                hold_left--;
            else
                out_ready <= quiet || ($urandom_range(0, 99) >= 21);
        end
    end

    // End the run when no beat moves for too long
    initial
    begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, stalled);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int                   pick;
        int unsigned          len;
        logic [IN_ADDR_W-1:0] a;
        logic [IN_ADDR_W-1:0] b;
        logic [IN_ADDR_W-1:0] t;

        tracker          = new;
        quiet            = 1'b0;
        hold_off_req     = 1'b0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        req_type        <= REQ_UPDATE;
        range_start_addr <= '0;
        range_end_addr  <= '0;
        set_value       <= 1'b0;
        query_addr      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: store clear after reset, lowest and highest pages
        send_query('0);
        send_query('1);
        // Widest range, end unaligned so the top page stays clear
        send_update('0, '1, 1'b1);
        send_query('0);
        send_query(32'hffff_efff);
        send_query(32'hffff_f000);
        // Clear across a byte boundary
        send_update(32'h0000_1000, 32'h0000_9000, 1'b0);
        send_query(32'h0000_1000);
        send_query(32'h0000_0fff);
        send_query(32'h0000_9000);
        // Start and end in one page: no change
        send_update(32'h0002_0123, 32'h0002_0fff, 1'b0);
        send_query(32'h0002_0000);
        // End below start: no change
        send_update(32'hffff_f000, 32'h0000_0000, 1'b0);
        send_query(32'h0010_0000);
        // Unaligned start and end
        send_update(32'h0003_0fff, 32'h0003_2001, 1'b0);
        send_query(32'h0003_0000);
        send_query(32'h0003_2000);
        // Partial bits inside a single byte
        send_update(32'h0004_1000, 32'h0004_6000, 1'b0);
        send_query(32'h0004_3000);
        send_query(32'h0004_0000);
        // Clear everything again, then an equal start and end
        send_update('0, '1, 1'b0);
        send_query(32'h7fff_f000);
        send_update(32'h8000_0000, 32'h8000_0000, 1'b1);
        wait_drained();

        // Random mix, mostly short ranges in a few hot windows
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= 600 && i < 800);
            if (i == 300 || i == 900)
                hold_off_req = 1'b1;
            if (i == 1000)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_query(hot_addr());
                else
                    send_query($urandom);
            end
            else if (pick < 82)
            begin
                a   = hot_addr();
                len = $urandom_range(0, 48);
                send_update(a, page_end(a, len), 1'($urandom));
            end
            else if (pick < 90)
            begin
                a   = $urandom;
                len = $urandom_range(0, 64);
                send_update(a, page_end(a, len), 1'($urandom));
            end
            else if (pick < 94)
            begin
                // Reversed range with every address bit random
                a = $urandom;
                b = $urandom;
                if (a < b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                send_update(a, b, 1'($urandom));
            end
            else if (pick < 98)
            begin
                // End a little below start; never let it wrap above
                a = hot_addr();
                b = a - (IN_ADDR_W'($urandom_range(1, 64)) << PAGE_SHIFT);
                if (b > a)
                    b = '0;
                send_update(a, b, 1'($urandom));
            end
            else
            begin
                a   = hot_addr();
                len = $urandom_range(64, 16384);
                send_update(a, page_end(a, len), 1'($urandom));
            end
        end
        quiet = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d range updates (%0d left the marks as they were) and %0d queries",
                 tracker.n_update, tracker.n_no_change, tracker.n_query);
        $display("(%0d on clear pages), with %0d mismatches found.",
                 tracker.n_clear_hit, tracker.errors);
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[page_bitmap_range_marker.f]
+incdir+rtl
rtl/pbm_pkg.sv
rtl/pbm_ram.sv
rtl/pbm_datapath.sv
rtl/pbm_ctrl.sv
rtl/page_bitmap_range_marker.sv
verif/tb.sv
